// File: rtl/core/hhtp_pkg.sv
// Shared widths, constants and handshake structs for the heading-hold thruster PWM controller.
package hhtp_pkg;

    localparam int MUL_A_W    = 48;
    localparam int MUL_B_W    = 20;
    localparam int ACC_W      = 64;
    localparam int DIV_W      = 54;
    localparam int QUO_W      = 26;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_TARGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_TARGET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 3'd5;

    // divider step counts, divisors pre-shifted by (steps - 1)
    localparam logic [STEP_W-1:0] STEPS_RAW = 5'd14;
    localparam logic [STEP_W-1:0] STEPS_HDG = 5'd26;
    localparam logic [STEP_W-1:0] STEPS_PWM = 5'd11;

    localparam logic [63:0] PWM_FWD_DIV  = 64'd65536 * 64'd981 * 64'd85;
    localparam logic [63:0] PWM_BWD_DIV  = 64'd981 * 64'd65536 * 64'd67;
    localparam logic [63:0] PWM_FWD_BIAS = 64'd1300806 * 64'd65536 * 64'd100;
    localparam logic [63:0] PWM_BWD_BASE = 64'd936855 * 64'd65536 * 64'd100;
    localparam logic [63:0] PWM_FWD_SAT  = PWM_FWD_DIV << 11;

    localparam logic [DIV_W-1:0] DSH_RAW = DIV_W'(64'd1000 << 13);
    localparam logic [DIV_W-1:0] DSH_HDG = DIV_W'(64'd40 << 25);
    localparam logic [DIV_W-1:0] DSH_FWD = DIV_W'(PWM_FWD_DIV << 10);
    localparam logic [DIV_W-1:0] DSH_BWD = DIV_W'(PWM_BWD_DIV << 10);

    localparam logic [63:0]        THRUST_MAX = 64'h0000_0001_0000_0000;
    localparam logic [MUL_B_W-1:0] PWM_SCALE  = 20'd1000000;

    localparam logic [10:0] PWM_MIN      = 11'd1300;
    localparam logic [10:0] PWM_MAX      = 11'd1700;
    localparam logic [10:0] PWM_NEUTRAL  = 11'd1500;
    localparam logic [10:0] PWM_DEADBAND = 11'd1543;

    typedef struct packed {
        logic start;
        logic keep;     // add onto the running accumulator
    } mul_cmd_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

endpackage

// File: rtl/core/hhtp_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier, one bit per cycle.
module hhtp_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hhtp_pkg::mul_cmd_t                   cmd,
    input  logic signed [hhtp_pkg::MUL_A_W-1:0]  a,
    input  logic        [hhtp_pkg::MUL_B_W-1:0]  b,
    output logic                                 done,
    output logic signed [hhtp_pkg::ACC_W-1:0]    acc
);
    import hhtp_pkg::*;

    logic signed [ACC_W-1:0]   a_sh_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic        [MUL_B_W-1:0] b_sh_reg;
    logic                      busy_reg;
    logic                      done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_sh_reg <= '0;
            acc_reg  <= '0;
            b_sh_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                a_sh_reg <= {{(ACC_W-MUL_A_W){a[MUL_A_W-1]}}, a};
                b_sh_reg <= b;
                if (!cmd.keep)
                begin
                    acc_reg <= '0;
                end
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // stop as soon as no multiplier bits remain
                if (b_sh_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    if (b_sh_reg[0])
                    begin
                        acc_reg <= acc_reg + a_sh_reg;
                    end
                    a_sh_reg <= a_sh_reg <<< 1;
                    b_sh_reg <= b_sh_reg >> 1;
                end
            end
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// File: rtl/core/hhtp_div.sv
// Restoring divider by a pre-shifted constant divisor, one quotient bit per cycle.
module hhtp_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hhtp_pkg::div_cmd_t             cmd,
    input  logic [hhtp_pkg::DIV_W-1:0]     num,
    input  logic [hhtp_pkg::DIV_W-1:0]     dsh,
    output logic                           done,
    output logic [hhtp_pkg::QUO_W-1:0]     quo,
    output logic                           rem_nz
);
    import hhtp_pkg::*;

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dsh_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                rem_reg  <= num;
                dsh_reg  <= dsh;
                quo_reg  <= '0;
                cnt_reg  <= cmd.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign quo    = quo_reg;
    assign rem_nz = (rem_reg != '0);

endmodule

// File: rtl/core/heading_hold_thruster_pwm_controller.sv
// Top level: heading-hold controller turning gyro samples into left/right thruster PWM words.
//
// Use: one input word per gyro sample (gyro_sample, stop_request, new_leg) on in_valid /
// in_stall; one result word per input (left_pwm, right_pwm, heading_now, goal_reached,
// stopped) on out_valid / out_stall. A word moves at a clock edge with valid high and stall
// low. Gains and targets are written on the cfg port (cfg_index, cfg_data, cfg_valid with
// cfg_ready always high) while no word is in flight.
// Timing is set by one shared bit-serial multiplier (one multiplier bit per cycle, seven
// products, each ending early once no multiplier bits remain) and one shared restoring
// divider (one quotient bit per cycle: /1000, /40 and two PWM curve divisions, a curve
// division skipped for zero or out-of-range thrust). A stop word goes from S_IDLE
// straight to S_DONE, which loads the result register. One word is processed at a time;
// in_stall is high while busy, so a new word is taken only once the last one is done.
// The result sits in an output register, so the next input word is taken while the previous
// result is still stalled; a finished word waits only if that register is still full.
// Reset: asynchronous, active low; filtered rate and heading clear to zero and the gain
// registers return to their defaults; out_valid drops.
module heading_hold_thruster_pwm_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [23:0]                   gyro_sample,
    input  logic                                 stop_request,
    input  logic                                 new_leg,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic        [10:0]                   left_pwm,
    output logic        [10:0]                   right_pwm,
    output logic signed [31:0]                   heading_now,
    output logic                                 goal_reached,
    output logic                                 stopped,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [hhtp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [hhtp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hhtp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RAW_GO, S_RAW_WT, S_FA_GO, S_FA_WT, S_FB_GO, S_FB_WT,
        S_HD_GO, S_HD_WT, S_ER_GO, S_ER_WT, S_OU_GO, S_OU_WT, S_SP_GO, S_SP_WT,
        S_PM_GO, S_PM_WT, S_PD_GO, S_PD_WT, S_PFIN, S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [25:0] ht_reg;
    logic [15:0]        ft_reg, hg_reg, rg_reg, fg_reg, sw_reg;

    // loop state and working values
    logic signed [31:0] f_reg, h_reg;
    logic signed [23:0] raw_reg;
    logic signed [14:0] rq_reg;
    logic signed [47:0] o_reg;
    logic signed [63:0] d_reg, tl_reg, tr_reg;
    logic               xneg_reg, side_reg, tneg_reg, tzero_reg, stop_reg;
    logic [DIV_W-1:0]   prod_reg;
    logic [10:0]        p_reg, lp_reg, rp_reg;

    // result register
    logic               out_valid_reg, goal_reg, stopped_reg;
    logic [10:0]        lpo_reg, rpo_reg;
    logic signed [31:0] hn_reg;

    // shared units
    mul_cmd_t                  mul_cmd;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic                      mul_done;
    logic signed [ACC_W-1:0]   acc;
    div_cmd_t                  div_cmd;
    logic [DIV_W-1:0]          div_num, div_dsh;
    logic                      div_done, rem_nz;
    logic [QUO_W-1:0]          quo;

    // datapath terms
    logic [23:0]        raw_mag;
    logic signed [14:0] rq_new;
    logic signed [63:0] fsum, esum, dsum, d_new, tl_new, tr_new, t_sel;
    logic signed [31:0] f_new;
    logic signed [32:0] x40;
    logic [32:0]        x_mag;
    logic [26:0]        q_ext;
    logic signed [26:0] qd;
    logic signed [32:0] hsum;
    logic signed [31:0] h_sat;
    logic signed [33:0] err;
    logic signed [47:0] o_new;
    logic [63:0]        t_abs;
    logic [32:0]        t_mag;
    logic [DIV_W-1:0]   fwd_num, bwd_num;
    logic               fwd_sat, bwd_zero, pd_div_go;
    logic [10:0]        pwm_c;
    logic               goal_now;

    hhtp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .acc   (acc)
    );

    hhtp_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (div_cmd),
        .num    (div_num),
        .dsh    (div_dsh),
        .done   (div_done),
        .quo    (quo),
        .rem_nz (rem_nz)
    );

    always_comb
    begin
        // raw rate / 1000, truncating toward zero
        raw_mag = raw_reg[23] ? (~raw_reg + 24'd1) : raw_reg;
        rq_new  = raw_reg[23] ? -$signed({1'b0, quo[13:0]}) : $signed({1'b0, quo[13:0]});

        // low-pass filter: round(acc / 65536)
        fsum  = acc + 64'sd32768;
        f_new = fsum[47:16];

        // heading step: floor((f + 20) / 40), then saturating add
        x40   = {f_reg[31], f_reg} + 33'sd20;
        x_mag = x40[32] ? 33'(-x40) : 33'(x40);
        q_ext = {1'b0, quo} + 27'(rem_nz && xneg_reg);
        qd    = xneg_reg ? -$signed(q_ext) : $signed(q_ext);
        hsum  = {h_reg[31], h_reg} + {{6{qd[26]}}, qd};
        if (hsum > 33'sd2147483647)
        begin
            h_sat = 32'sh7FFF_FFFF;
        end
        else if (hsum < -33'sd2147483648)
        begin
            h_sat = 32'sh8000_0000;
        end
        else
        begin
            h_sat = hsum[31:0];
        end

        // cascaded P terms
        err    = {{8{ht_reg[25]}}, ht_reg} - {{2{h_reg[31]}}, h_reg};
        esum   = acc + 64'sd128;
        o_new  = esum[55:8] - {{16{f_reg[31]}}, f_reg};
        dsum   = acc + 64'sd128;
        d_new  = dsum >>> 8;
        tl_new = (acc - d_reg + 64'sd1) >>> 1;
        tr_new = (acc + d_reg + 64'sd1) >>> 1;

        // side thrust magnitude, clamped
        t_sel = side_reg ? tr_reg : tl_reg;
        t_abs = t_sel[63] ? 64'(-t_sel) : 64'(t_sel);
        t_mag = (t_abs > THRUST_MAX) ? THRUST_MAX[32:0] : t_abs[32:0];

        // thrust curve numerators
        fwd_num   = prod_reg + PWM_FWD_BIAS[DIV_W-1:0];
        fwd_sat   = (fwd_num >= PWM_FWD_SAT[DIV_W-1:0]);
        bwd_zero  = (prod_reg >= PWM_BWD_BASE[DIV_W-1:0]);
        bwd_num   = PWM_BWD_BASE[DIV_W-1:0] - prod_reg;
        pd_div_go = !tzero_reg && (tneg_reg ? !bwd_zero : !fwd_sat);

        // forward deadband, then output clamp
        pwm_c = p_reg;
        if (!tneg_reg && !tzero_reg && (p_reg <= PWM_DEADBAND))
        begin
            pwm_c = PWM_NEUTRAL;
        end
        if (pwm_c < PWM_MIN)
        begin
            pwm_c = PWM_MIN;
        end
        else if (pwm_c > PWM_MAX)
        begin
            pwm_c = PWM_MAX;
        end

        goal_now = ($signed({h_reg[31], h_reg}) >= $signed({{7{ht_reg[25]}}, ht_reg}));
    end

    // unit command steering
    always_comb
    begin
        mul_cmd = '0;
        mul_a   = '0;
        mul_b   = '0;
        div_cmd = '0;
        div_num = '0;
        div_dsh = '0;
        case (state_reg)
            S_RAW_GO:
            begin
                div_cmd.start = 1'b1;
                div_cmd.steps = STEPS_RAW;
                div_num       = {{(DIV_W-24){1'b0}}, raw_mag};
                div_dsh       = DSH_RAW;
            end
            S_FA_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_a         = {{(MUL_A_W-32){f_reg[31]}}, f_reg};
                mul_b         = MUL_B_W'(32'd65536 - {16'd0, sw_reg});
            end
            S_FB_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.keep  = 1'b1;
                mul_a         = {{(MUL_A_W-31){rq_reg[14]}}, rq_reg, 16'd0};
                mul_b         = {{(MUL_B_W-16){1'b0}}, sw_reg};
            end
            S_HD_GO:
            begin
                div_cmd.start = 1'b1;
                div_cmd.steps = STEPS_HDG;
                div_num       = {{(DIV_W-33){1'b0}}, x_mag};
                div_dsh       = DSH_HDG;
            end
            S_ER_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_a         = {{(MUL_A_W-34){err[33]}}, err};
                mul_b         = {{(MUL_B_W-16){1'b0}}, hg_reg};
            end
            S_OU_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_a         = o_reg;
                mul_b         = {{(MUL_B_W-16){1'b0}}, rg_reg};
            end
            S_SP_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_a         = {{(MUL_A_W-16){1'b0}}, ft_reg};
                mul_b         = {{(MUL_B_W-16){1'b0}}, fg_reg};
            end
            S_PM_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_a         = {{(MUL_A_W-33){1'b0}}, t_mag};
                mul_b         = PWM_SCALE;
            end
            S_PD_GO:
            begin
                div_cmd.start = pd_div_go;
                div_cmd.steps = STEPS_PWM;
                div_num       = tneg_reg ? bwd_num : fwd_num;
                div_dsh       = tneg_reg ? DSH_BWD : DSH_FWD;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ht_reg        <= '0;
            ft_reg        <= 16'd128;
            hg_reg        <= 16'd256;
            rg_reg        <= 16'd51;
            fg_reg        <= 16'd384;
            sw_reg        <= 16'd9830;
            f_reg         <= '0;
            h_reg         <= '0;
            raw_reg       <= '0;
            rq_reg        <= '0;
            o_reg         <= '0;
            d_reg         <= '0;
            tl_reg        <= '0;
            tr_reg        <= '0;
            xneg_reg      <= 1'b0;
            side_reg      <= 1'b0;
            tneg_reg      <= 1'b0;
            tzero_reg     <= 1'b0;
            stop_reg      <= 1'b0;
            prod_reg      <= '0;
            p_reg         <= '0;
            lp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
            goal_reg      <= 1'b0;
            stopped_reg   <= 1'b0;
            lpo_reg       <= '0;
            rpo_reg       <= '0;
            hn_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_HEADING_TARGET:   ht_reg <= $signed(cfg_data);
                    CFG_FORWARD_TARGET:   ft_reg <= cfg_data[15:0];
                    CFG_HEADING_GAIN:     hg_reg <= cfg_data[15:0];
                    CFG_RATE_GAIN:        rg_reg <= cfg_data[15:0];
                    CFG_FORWARD_GAIN:     fg_reg <= cfg_data[15:0];
                    CFG_SMOOTHING_WEIGHT: sw_reg <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end

            // drain; a reload in S_DONE takes over this edge
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        raw_reg  <= gyro_sample;
                        stop_reg <= stop_request;
                        if (stop_request)
                        begin
                            // neutral output, state untouched
                            lp_reg    <= PWM_NEUTRAL;
                            rp_reg    <= PWM_NEUTRAL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            if (new_leg)
                            begin
                                f_reg <= '0;
                            end
                            state_reg <= S_RAW_GO;
                        end
                    end
                end
                S_RAW_GO: state_reg <= S_RAW_WT;
                S_RAW_WT:
                begin
                    if (div_done)
                    begin
                        rq_reg    <= rq_new;
                        state_reg <= S_FA_GO;
                    end
                end
                S_FA_GO: state_reg <= S_FA_WT;
                S_FA_WT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_FB_GO;
                    end
                end
                S_FB_GO: state_reg <= S_FB_WT;
                S_FB_WT:
                begin
                    if (mul_done)
                    begin
                        f_reg     <= f_new;
                        state_reg <= S_HD_GO;
                    end
                end
                S_HD_GO:
                begin
                    xneg_reg  <= x40[32];
                    state_reg <= S_HD_WT;
                end
                S_HD_WT:
                begin
                    if (div_done)
                    begin
                        h_reg     <= h_sat;
                        state_reg <= S_ER_GO;
                    end
                end
                S_ER_GO: state_reg <= S_ER_WT;
                S_ER_WT:
                begin
                    if (mul_done)
                    begin
                        o_reg     <= o_new;
                        state_reg <= S_OU_GO;
                    end
                end
                S_OU_GO: state_reg <= S_OU_WT;
                S_OU_WT:
                begin
                    if (mul_done)
                    begin
                        d_reg     <= d_new;
                        state_reg <= S_SP_GO;
                    end
                end
                S_SP_GO: state_reg <= S_SP_WT;
                S_SP_WT:
                begin
                    if (mul_done)
                    begin
                        // acc holds the forward thrust term
                        tl_reg    <= tl_new;
                        tr_reg    <= tr_new;
                        side_reg  <= 1'b0;
                        state_reg <= S_PM_GO;
                    end
                end
                S_PM_GO:
                begin
                    tneg_reg  <= t_sel[63];
                    tzero_reg <= (t_sel == '0);
                    state_reg <= S_PM_WT;
                end
                S_PM_WT:
                begin
                    if (mul_done)
                    begin
                        prod_reg  <= acc[DIV_W-1:0];
                        state_reg <= S_PD_GO;
                    end
                end
                S_PD_GO:
                begin
                    if (pd_div_go)
                    begin
                        state_reg <= S_PD_WT;
                    end
                    else
                    begin
                        if (tzero_reg)
                        begin
                            p_reg <= PWM_NEUTRAL;
                        end
                        else if (tneg_reg)
                        begin
                            p_reg <= '0;
                        end
                        else
                        begin
                            p_reg <= PWM_MAX;
                        end
                        state_reg <= S_PFIN;
                    end
                end
                S_PD_WT:
                begin
                    if (div_done)
                    begin
                        p_reg     <= quo[10:0];
                        state_reg <= S_PFIN;
                    end
                end
                S_PFIN:
                begin
                    if (!side_reg)
                    begin
                        lp_reg    <= pwm_c;
                        side_reg  <= 1'b1;
                        state_reg <= S_PM_GO;
                    end
                    else
                    begin
                        rp_reg    <= pwm_c;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // load when the result register is empty or drains this edge
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        lpo_reg       <= lp_reg;
                        rpo_reg       <= rp_reg;
                        hn_reg        <= h_reg;
                        goal_reg      <= goal_now;
                        stopped_reg   <= stop_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign left_pwm     = lpo_reg;
    assign right_pwm    = rpo_reg;
    assign heading_now  = hn_reg;
    assign goal_reached = goal_reg;
    assign stopped      = stopped_reg;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the heading-hold thruster PWM controller.
`timescale 1ns / 1ps

module tb;
    import hhtp_pkg::*;

    // predictor constants, all 64-bit so no product overflows
    localparam longint FWD_BIAS = 64'sd1300806 * 64'sd65536;
    localparam longint FWD_DIV  = 64'sd65536 * 64'sd981 * 64'sd85;
    localparam longint BWD_BASE = 64'sd936855 * 64'sd65536;
    localparam longint BWD_DIV  = 64'sd981 * 64'sd65536 * 64'sd67;
    localparam longint T_LIMIT  = 64'sd4294967296;

    typedef struct {
        logic [10:0]        left;
        logic [10:0]        right;
        logic signed [31:0] heading;
        logic               goal;
        logic               stop;
    } pwm_word_t;

    // directed row: typed rows carry known PWM and stop flag
    typedef struct {
        logic signed [23:0] gyro;
        logic               stop;
        logic               leg;
        logic               typed;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic signed [23:0]    gyro_sample = '0;
    logic                  stop_request = 1'b0;
    logic                  new_leg = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [10:0]           left_pwm;
    logic [10:0]           right_pwm;
    logic signed [31:0]    heading_now;
    logic                  goal_reached;
    logic                  stopped;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of registers and state
    longint    m_target;
    longint    m_fwd_tgt;
    longint    m_hdg_gain;
    longint    m_rate_gain;
    longint    m_fwd_gain;
    longint    m_weight;
    longint    m_rate;
    longint    m_heading;

    pwm_word_t pending_words[$];
    int        errors = 0;
    bit        idle_on = 1'b1;
    int        stall_left = 0;

    heading_hold_thruster_pwm_controller dut (.*);

    always #1 clk = ~clk;

    function automatic longint floor_div(longint x, longint d);
        longint q;
        q = x / d;
        if ((x % d) != 0 && x < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint round_div(longint x, longint d);
        return floor_div(x + d / 2, d);
    endfunction

    function automatic logic [10:0] thrust_pwm(longint t);
        longint p;
        longint mm;
        if (t > T_LIMIT) t = T_LIMIT;
        if (t < -T_LIMIT) t = -T_LIMIT;
        if (t > 0)
        begin
            p = ((t * 10000 + FWD_BIAS) * 100) / FWD_DIV;
            if (p <= 1543) p = 1500;
        end
        else if (t == 0)
            p = 1500;
        else
        begin
            mm = -t * 10000;
            // backward curve at or below zero pins to the low clamp
            if (mm >= BWD_BASE)
                p = 0;
            else
                p = ((BWD_BASE - mm) * 100) / BWD_DIV;
        end
        if (p < 1300) p = 1300;
        if (p > 1700) p = 1700;
        return p[10:0];
    endfunction

    // advance the predictor by one accepted word and return its result
    function automatic pwm_word_t steer_predict(logic signed [23:0] g, logic s, logic l);
        pwm_word_t w;
        longint    r;
        longint    h;
        longint    outer;
        longint    diff;
        longint    fsum;
        w.left  = 11'd1500;
        w.right = 11'd1500;
        if (!s)
        begin
            r = (longint'(g) / 1000) * 65536;
            if (l)
                m_rate = 0;
            m_rate = round_div(m_rate * (65536 - m_weight) + r * m_weight, 65536);
            h = m_heading + round_div(m_rate, 40);
            if (h > 64'sd2147483647) h = 64'sd2147483647;
            if (h < -64'sd2147483648) h = -64'sd2147483648;
            m_heading = h;
            outer = round_div((m_target - m_heading) * m_hdg_gain, 256) - m_rate;
            diff  = round_div(outer * m_rate_gain, 256);
            fsum  = m_fwd_tgt * m_fwd_gain;
            w.left  = thrust_pwm(round_div(fsum - diff, 2));
            w.right = thrust_pwm(round_div(fsum + diff, 2));
        end
        w.heading = m_heading[31:0];
        w.goal    = (m_heading >= m_target);
        w.stop    = s;
        return w;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_HEADING_TARGET:   m_target    = longint'(signed'(cfg_data));
            CFG_FORWARD_TARGET:   m_fwd_tgt   = cfg_data[15:0];
            CFG_HEADING_GAIN:     m_hdg_gain  = cfg_data[15:0];
            CFG_RATE_GAIN:        m_rate_gain = cfg_data[15:0];
            CFG_FORWARD_GAIN:     m_fwd_gain  = cfg_data[15:0];
            CFG_SMOOTHING_WEIGHT: m_weight    = cfg_data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // send one word; typed rows replace the PWM and stop flag by known values
    task automatic send_word(logic signed [23:0] g, logic s, logic l, logic typed);
        int        gap;
        pwm_word_t w;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        gyro_sample  = g;
        stop_request = s;
        new_leg      = l;
        do @(posedge clk); while (in_stall);
        w = steer_predict(g, s, l);
        if (typed)
        begin
            w.left  = 11'd1500;
            w.right = 11'd1500;
            w.stop  = 1'b1;
        end
        pending_words.push_back(w);
        @(negedge clk);
    endtask

    // wait for the result queue to drain, then let the datapath settle
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    function automatic logic signed [23:0] rand_gyro();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 24'(int'($urandom_range(0, 40000)) - 20000);
        else if (sel < 80)
            return 24'($urandom);
        else
            case ($urandom_range(0, 6))
                0: return 24'sh7FFFFF;
                1: return 24'sh800000;
                2: return 24'sd999;
                3: return -24'sd999;
                4: return 24'sd1000;
                5: return -24'sd1000;
                default: return '0;
            endcase
    endfunction

    // output stall: held high while the checker's stall_left countdown is nonzero
    always @(negedge clk)
    begin
        out_stall <= (stall_left > 0);
    end

    // result checker; also counts down the output stall
    always @(posedge clk)
    begin
        pwm_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            stall_left <= idle_on ? $urandom_range(0, 4) : 0;
            if (pending_words.size() == 0)
            begin
                $error("result word with no expectation");
                errors++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (left_pwm !== w.left)
                begin
                    $error("left_pwm exp %0d got %0d", w.left, left_pwm);
                    errors++;
                end
                if (right_pwm !== w.right)
                begin
                    $error("right_pwm exp %0d got %0d", w.right, right_pwm);
                    errors++;
                end
                if (heading_now !== w.heading)
                begin
                    $error("heading_now exp %0d got %0d", w.heading, heading_now);
                    errors++;
                end
                if (goal_reached !== w.goal)
                begin
                    $error("goal_reached exp %0d got %0d", w.goal, goal_reached);
                    errors++;
                end
                if (stopped !== w.stop)
                begin
                    $error("stopped exp %0d got %0d", w.stop, stopped);
                    errors++;
                end
            end
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    initial
    begin
        #4000000;
        $display("heading_hold_thruster_pwm_controller verification failed");
        $finish;
    end

    initial
    begin
        row_t   rows[$];
        longint cfg_val[6];
        int     n;
        int     run_len;
        logic signed [23:0] run_g;
        bit     held;

        m_target    = 0;
        m_fwd_tgt   = 128;
        m_hdg_gain  = 256;
        m_rate_gain = 51;
        m_fwd_gain  = 384;
        m_weight    = 9830;
        m_rate      = 0;
        m_heading   = 0;
        held        = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: stop right after reset, rounding of the /1000 cut,
        // field extremes, new leg and stop with new leg set
        rows = '{
            '{24'sd0, 1'b1, 1'b0, 1'b1},
            '{24'sd0, 1'b0, 1'b0, 1'b0},
            '{24'sd999, 1'b0, 1'b0, 1'b0},
            '{-24'sd999, 1'b0, 1'b0, 1'b0},
            '{24'sd1000, 1'b0, 1'b0, 1'b0},
            '{-24'sd1000, 1'b0, 1'b0, 1'b0},
            '{24'sh7FFFFF, 1'b0, 1'b0, 1'b0},
            '{24'sh7FFFFF, 1'b0, 1'b0, 1'b0},
            '{24'sh800000, 1'b0, 1'b0, 1'b0},
            '{24'sh800000, 1'b0, 1'b1, 1'b0},
            '{24'sh7FFFFF, 1'b1, 1'b1, 1'b1},
            '{24'sh7FFFFF, 1'b0, 1'b1, 1'b0},
            '{24'sh555555, 1'b0, 1'b0, 1'b0},
            '{24'shAAAAAA, 1'b0, 1'b0, 1'b0},
            '{24'sd1, 1'b1, 1'b0, 1'b1},
            '{-24'sd1, 1'b0, 1'b0, 1'b0}
        };
        foreach (rows[i])
            send_word(rows[i].gyro, rows[i].stop, rows[i].leg, rows[i].typed);
        drain();

        // random phases; phase 0 all minimum, phase 1 all maximum
        for (int p = 0; p < 6; p++)
        begin
            if (p == 0)
                cfg_val = '{-23592960, 0, 0, 0, 0, 0};
            else if (p == 1)
                cfg_val = '{23592960, 65535, 65535, 65535, 65535, 65535};
            else
                cfg_val = '{int'($urandom_range(0, 47185920)) - 23592960,
                            $urandom_range(0, 65535), $urandom_range(0, 1024),
                            $urandom_range(0, 1024), $urandom_range(0, 65535),
                            $urandom_range(0, 65535)};
            for (int r = 0; r < 6; r++)
                cfg_write(r[CFG_IDX_W-1:0], cfg_val[r]);
            idle_on = (p != 3);
            n = 0;
            while (n < 230)
            begin
                // sustained turns drive the heading toward saturation
                if ($urandom_range(0, 9) == 0)
                begin
                    run_len = $urandom_range(10, 40);
                    run_g   = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                    repeat (run_len)
                        send_word(run_g - 24'($urandom_range(0, 3000)), 1'b0, 1'b0, 1'b0);
                    n += run_len;
                end
                else
                begin
                    send_word(rand_gyro(), $urandom_range(0, 9) == 0,
                              $urandom_range(0, 7) == 0, 1'b0);
                    n++;
                end
                // hold off once, mid-way through phase 2, until every result is back
                if (!held && n >= 100 && p == 2)
                begin
                    held     = 1'b1;
                    in_valid = 1'b0;
                    while (pending_words.size() != 0) @(negedge clk);
                end
            end
            drain();
        end

        if (errors == 0 && pending_words.size() == 0)
            $display("heading_hold_thruster_pwm_controller verification clean");
        else
            $display("heading_hold_thruster_pwm_controller verification failed");
        $finish;
    end

endmodule
